// ----- hdl/mts_pkg.sv -----
// Shared types, constants and helpers for the memory test sequencer.
// Used by every module of the sequencer; depends on nothing else.
package mts_pkg;

   localparam int ADDR_W     = 16;
   localparam int ADDR_LINES = 11;
   localparam int LINE_W     = 4;
   localparam int DATA_W     = 8;
   localparam int KIND_W     = 3;
   localparam int STEP_W     = $clog2(ADDR_LINES + 2);

   localparam int CMD_DEPTH  = 4;
   localparam int CMD_PTR_W  = $clog2(CMD_DEPTH);
   localparam int RSP_DEPTH  = 2;
   localparam int RSP_PTR_W  = $clog2(RSP_DEPTH);

   localparam int CSR_IDX_W  = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_START = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_END   = 1'b1;

   localparam logic [ADDR_W-1:0] START_RESET = 16'h2200;
   localparam logic [ADDR_W-1:0] END_RESET   = 16'hFFFF;

   localparam logic [DATA_W-1:0] PAT_ZERO = 8'h00;
   localparam logic [DATA_W-1:0] PAT_ONES = 8'hFF;
   localparam logic [DATA_W-1:0] PAT_A    = 8'hAA;
   localparam logic [DATA_W-1:0] PAT_B    = 8'h55;

   localparam logic OP_START = 1'b0;
   localparam logic OP_READ  = 1'b1;

   localparam logic [KIND_W-1:0] KIND_WRITE   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_READ    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_AFAULT  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_DFAULT  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_CATA    = 3'd4;
   localparam logic [KIND_W-1:0] KIND_COMPL   = 3'd5;
   localparam logic [KIND_W-1:0] KIND_PASS    = 3'd6;

   typedef struct packed {
      logic              op;
      logic [DATA_W-1:0] read_data;
   } req_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [ADDR_W-1:0] address;
      logic [DATA_W-1:0] data;
      logic [LINE_W-1:0] line;
      logic [DATA_W-1:0] bit_mask;
      logic              last;
   } rsp_type;

   // One classified input: the set of beat groups it expands into.
   typedef struct packed {
      logic              rep;
      logic              flt;
      logic              beg;
      logic              rdl;
      logic              wr;
      logic [ADDR_W-1:0] addr;
      logic [KIND_W-1:0] rep_kind;
      logic [DATA_W-1:0] rep_data;
      logic [DATA_W-1:0] rep_mask;
      logic [DATA_W-1:0] flt_data;
      logic [LINE_W-1:0] flt_line;
      logic [LINE_W-1:0] next_line;
      logic [DATA_W-1:0] pattern;
   } cmd_type;

   // Address plus two to the power of the line index, wrapping at ADDR_W bits.
   function automatic logic [ADDR_W-1:0] line_addr(input logic [ADDR_W-1:0] base,
                                                   input logic [LINE_W-1:0] idx);
      line_addr = base + (ADDR_W'(1) << idx);
   endfunction

endpackage

// ----- hdl/mts_front.sv -----
// Front end of the memory test sequencer: configuration registers, test state
// and classification of each accepted beat into a command. Uses mts_pkg.
module mts_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [mts_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mts_pkg::ADDR_W-1:0]         csr_wdata,
   input  logic                               accept,
   input  mts_pkg::req_type                   req,
   output logic                               cmd_valid,
   output mts_pkg::cmd_type                   cmd
);

   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_LINES = 3'd1;
   localparam logic [2:0] PH_CHECK = 3'd2;
   localparam logic [2:0] PH_COMPL = 3'd3;
   localparam logic [2:0] PH_HALT  = 3'd4;

   logic [mts_pkg::ADDR_W-1:0] start_ff, end_ff, taddr_ff, taddr_in;
   logic [mts_pkg::LINE_W-1:0] line_ff, line_in, nl;
   logic [mts_pkg::DATA_W-1:0] pat_ff, pat_in, rd, np;
   logic [2:0]                 phase_ff, phase_in;

   always_comb begin
      cmd       = '0;
      cmd.addr  = taddr_ff;
      cmd_valid = 1'b0;
      taddr_in  = taddr_ff;
      line_in   = line_ff;
      pat_in    = pat_ff;
      phase_in  = phase_ff;
      rd        = req.read_data;
      nl        = line_ff + mts_pkg::LINE_W'(1);
      np        = (pat_ff == mts_pkg::PAT_A) ? mts_pkg::PAT_B : mts_pkg::PAT_A;
      if (accept) begin
         if (req.op == mts_pkg::OP_START) begin
            cmd_valid = 1'b1;
            cmd.beg   = 1'b1;
            cmd.addr  = start_ff;
            taddr_in  = start_ff;
            pat_in    = mts_pkg::PAT_ZERO;
            line_in   = mts_pkg::LINE_W'(1);
            phase_in  = PH_LINES;
         end else begin
            case (phase_ff)
               PH_LINES: begin
                  cmd_valid    = 1'b1;
                  cmd.flt      = (rd != mts_pkg::PAT_ZERO);
                  cmd.flt_data = rd;
                  cmd.flt_line = line_ff;
                  if (nl != '0 && {1'b0, nl} < (mts_pkg::LINE_W + 1)'(mts_pkg::ADDR_LINES)) begin
                     cmd.rdl       = 1'b1;
                     cmd.next_line = nl;
                     line_in       = nl;
                  end else begin
                     cmd.wr      = 1'b1;
                     cmd.pattern = mts_pkg::PAT_A;
                     line_in     = '0;
                     pat_in      = mts_pkg::PAT_A;
                     phase_in    = PH_CHECK;
                  end
               end
               PH_CHECK: begin
                  cmd_valid = 1'b1;
                  if (rd == pat_ff) begin
                     if (pat_ff == mts_pkg::PAT_A) begin
                        cmd.wr      = 1'b1;
                        cmd.pattern = mts_pkg::PAT_B;
                        pat_in      = mts_pkg::PAT_B;
                     end else if (taddr_ff == end_ff) begin
                        cmd.rep      = 1'b1;
                        cmd.rep_kind = mts_pkg::KIND_PASS;
                        phase_in     = PH_HALT;
                     end else begin
                        cmd.beg  = 1'b1;
                        cmd.addr = taddr_ff + mts_pkg::ADDR_W'(1);
                        taddr_in = taddr_ff + mts_pkg::ADDR_W'(1);
                        line_in  = mts_pkg::LINE_W'(1);
                        phase_in = PH_LINES;
                     end
                  end else if (rd == mts_pkg::PAT_ZERO) begin
                     cmd.rep      = 1'b1;
                     cmd.rep_kind = mts_pkg::KIND_CATA;
                     cmd.rep_data = pat_ff;
                     phase_in     = PH_HALT;
                  end else begin
                     cmd.rep      = 1'b1;
                     cmd.rep_kind = mts_pkg::KIND_DFAULT;
                     cmd.rep_data = pat_ff;
                     cmd.rep_mask = rd ^ pat_ff;
                     cmd.wr       = 1'b1;
                     cmd.pattern  = np;
                     pat_in       = np;
                     phase_in     = PH_COMPL;
                  end
               end
               PH_COMPL: begin
                  cmd_valid    = 1'b1;
                  cmd.rep      = 1'b1;
                  cmd.rep_kind = mts_pkg::KIND_COMPL;
                  cmd.rep_data = rd;
                  cmd.rep_mask = rd ^ pat_ff;
                  phase_in     = PH_HALT;
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= mts_pkg::START_RESET;
         end_ff   <= mts_pkg::END_RESET;
         taddr_ff <= mts_pkg::START_RESET;
         line_ff  <= '0;
         pat_ff   <= '0;
         phase_ff <= PH_IDLE;
      end else begin
         if (csr_we && csr_index == mts_pkg::CSR_START) begin
            start_ff <= csr_wdata;
         end
         if (csr_we && csr_index == mts_pkg::CSR_END) begin
            end_ff <= csr_wdata;
         end
         taddr_ff <= taddr_in;
         line_ff  <= line_in;
         pat_ff   <= pat_in;
         phase_ff <= phase_in;
      end
   end

endmodule

// ----- hdl/mts_cmd_queue.sv -----
// Short command queue between the front and back ends of the sequencer.
// Uses mts_pkg for the command type and depth.
module mts_cmd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  mts_pkg::cmd_type push_data,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output mts_pkg::cmd_type pop_data
);

   mts_pkg::cmd_type                 mem_ff [mts_pkg::CMD_DEPTH];
   logic [mts_pkg::CMD_PTR_W-1:0]    wptr_ff, rptr_ff;
   logic [mts_pkg::CMD_PTR_W:0]      count_ff, count_in;
   logic                             wr_en, rd_en;

   assign full     = (count_ff == (mts_pkg::CMD_PTR_W + 1)'(mts_pkg::CMD_DEPTH));
   assign empty    = (count_ff == '0);
   assign wr_en    = push && !full;
   assign rd_en    = pop && !empty;
   assign pop_data = mem_ff[rptr_ff];

   always_comb begin
      count_in = count_ff;
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (wr_en) begin
            wptr_ff <= wptr_ff + 1'b1;
         end
         if (rd_en) begin
            rptr_ff <= rptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

endmodule

// ----- hdl/mts_back.sv -----
// Back end of the sequencer: expands each command into result beats, one per cycle
// while out_full is low, in the fixed order report, fault, clear, sweep, read, write,
// read. Uses mts_pkg.
module mts_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_avail,
   input  mts_pkg::cmd_type cmd,
   output logic             cmd_take,
   input  logic             out_full,
   output logic             out_push,
   output mts_pkg::rsp_type beat
);

   mts_pkg::cmd_type            cmd_ff;
   logic                        rep_ff, flt_ff, clr_ff, beg_ff, rdl_ff, wr_ff, rdb_ff;
   logic                        rep_c, flt_c, clr_c, beg_c, rdl_c, wr_c, rdb_c;
   logic [mts_pkg::STEP_W-1:0]  cnt_ff, cnt_c;
   logic                        busy, fire, more;

   assign busy = rep_ff | flt_ff | clr_ff | beg_ff | rdl_ff | wr_ff | rdb_ff;

   always_comb begin
      beat          = '0;
      beat.kind     = mts_pkg::KIND_WRITE;
      beat.address  = cmd_ff.addr;
      {rep_c, flt_c, clr_c, beg_c, rdl_c, wr_c, rdb_c} =
         {rep_ff, flt_ff, clr_ff, beg_ff, rdl_ff, wr_ff, rdb_ff};
      cnt_c         = cnt_ff;
      if (rep_ff) begin
         beat.kind     = cmd_ff.rep_kind;
         beat.data     = cmd_ff.rep_data;
         beat.bit_mask = cmd_ff.rep_mask;
         rep_c         = 1'b0;
      end else if (flt_ff) begin
         beat.kind = mts_pkg::KIND_AFAULT;
         beat.data = cmd_ff.flt_data;
         beat.line = cmd_ff.flt_line;
         flt_c     = 1'b0;
      end else if (clr_ff) begin
         beat.address = mts_pkg::line_addr(cmd_ff.addr, cmd_ff.flt_line);
         clr_c        = 1'b0;
      end else if (beg_ff) begin
         cnt_c = cnt_ff + 1'b1;
         if (cnt_ff < mts_pkg::STEP_W'(mts_pkg::ADDR_LINES)) begin
            beat.address = mts_pkg::line_addr(cmd_ff.addr, mts_pkg::LINE_W'(cnt_ff));
         end else if (cnt_ff == mts_pkg::STEP_W'(mts_pkg::ADDR_LINES)) begin
            beat.data = mts_pkg::PAT_ONES;
         end else begin
            beat.kind    = mts_pkg::KIND_READ;
            beat.address = mts_pkg::line_addr(cmd_ff.addr, mts_pkg::LINE_W'(1));
            beg_c        = 1'b0;
         end
      end else if (rdl_ff) begin
         beat.kind    = mts_pkg::KIND_READ;
         beat.address = mts_pkg::line_addr(cmd_ff.addr, cmd_ff.next_line);
         rdl_c        = 1'b0;
      end else if (wr_ff) begin
         beat.data = cmd_ff.pattern;
         wr_c      = 1'b0;
      end else begin
         beat.kind = mts_pkg::KIND_READ;
         rdb_c     = 1'b0;
      end
      more      = rep_c | flt_c | clr_c | beg_c | rdl_c | wr_c | rdb_c;
      beat.last = !more;
   end

   assign fire     = busy && !out_full;
   assign out_push = fire;
   assign cmd_take = cmd_avail && (!busy || (fire && !more));

   always_ff @(posedge clock) begin
      if (cmd_take) begin
         cmd_ff <= cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         {rep_ff, flt_ff, clr_ff, beg_ff, rdl_ff, wr_ff, rdb_ff} <= '0;
         cnt_ff <= '0;
      end else if (cmd_take) begin
         rep_ff <= cmd.rep;
         flt_ff <= cmd.flt;
         clr_ff <= cmd.flt;
         beg_ff <= cmd.beg;
         rdl_ff <= cmd.rdl;
         wr_ff  <= cmd.wr;
         rdb_ff <= cmd.wr;
         cnt_ff <= '0;
      end else if (fire) begin
         {rep_ff, flt_ff, clr_ff, beg_ff, rdl_ff, wr_ff, rdb_ff} <=
            {rep_c, flt_c, clr_c, beg_c, rdl_c, wr_c, rdb_c};
         cnt_ff <= cnt_c;
      end
   end

endmodule

// ----- hdl/mts_rsp_queue.sv -----
// Two-entry result queue that parts the back end from the result port.
// Uses mts_pkg for the result type and depth.
module mts_rsp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  mts_pkg::rsp_type push_data,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output mts_pkg::rsp_type pop_data
);

   mts_pkg::rsp_type                 mem_ff [mts_pkg::RSP_DEPTH];
   logic [mts_pkg::RSP_PTR_W-1:0]    wptr_ff, rptr_ff;
   logic [mts_pkg::RSP_PTR_W:0]      count_ff, count_in;
   logic                             wr_en, rd_en;

   assign full     = (count_ff == (mts_pkg::RSP_PTR_W + 1)'(mts_pkg::RSP_DEPTH));
   assign empty    = (count_ff == '0);
   assign wr_en    = push && !full;
   assign rd_en    = pop && !empty;
   assign pop_data = mem_ff[rptr_ff];

   always_comb begin
      count_in = count_ff;
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (wr_en) begin
            wptr_ff <= wptr_ff + 1'b1;
         end
         if (rd_en) begin
            rptr_ff <= rptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

endmodule

// ----- hdl/memory_test_sequencer_top.sv -----
// Memory test sequencer top level. The first result beat of an input passes through the
// command queue, the back-end command register and the result queue to the rsp_ ports; the
// back end then emits one beat per cycle while the result queue has room, and an input
// yields 1 to 13 beats (13 when a new address sweep starts). Inputs are taken every cycle
// until the four-entry command queue fills. Synchronous active-high reset sets start 0x2200,
// end 0xFFFF, the test idle and both queues empty; there is no clearing pass.
module memory_test_sequencer_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [mts_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mts_pkg::ADDR_W-1:0]    csr_wdata,
   input  logic                          req_push,
   output logic                          req_full,
   input  mts_pkg::req_type              req_data,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output mts_pkg::rsp_type              rsp_data
);

   // The front end owns the test state and turns each accepted beat into at most one command.
   logic             accept;
   logic             cmd_valid;
   mts_pkg::cmd_type cmd;

   // The command queue lets the front end keep taking beats while the back end
   // is still expanding an earlier command.
   logic             cq_empty;
   logic             cq_take;
   mts_pkg::cmd_type cq_data;

   // The back end pushes one result beat per cycle into the result queue while it has room.
   logic             rq_full;
   logic             rq_push;
   mts_pkg::rsp_type beat;

   assign accept = req_push && !req_full;

   mts_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .req       (req_data),
      .cmd_valid (cmd_valid),
      .cmd       (cmd)
   );

   // A beat that causes no result (read data while idle or halted) pushes nothing.
   mts_cmd_queue u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_valid),
      .push_data (cmd),
      .full      (req_full),
      .pop       (cq_take),
      .empty     (cq_empty),
      .pop_data  (cq_data)
   );

   mts_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_avail (!cq_empty),
      .cmd       (cq_data),
      .cmd_take  (cq_take),
      .out_full  (rq_full),
      .out_push  (rq_push),
      .beat      (beat)
   );

   // The result queue holds finished beats so that a stalled consumer only stops the back end.
   mts_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rq_push),
      .push_data (beat),
      .full      (rq_full),
      .pop       (rsp_pop),
      .empty     (rsp_empty),
      .pop_data  (rsp_data)
   );

endmodule

// ----- verif/mts_tb_pkg.sv -----
// Scoreboard for the memory test sequencer testbench: sweep predictor and beat checker.
// Depends on mts_pkg for the request and response beat types and the sequencer constants.
package mts_tb_pkg;

   import mts_pkg::*;

   typedef enum logic [2:0] {SEQ_IDLE, SEQ_LINES, SEQ_CHECK, SEQ_COMPL, SEQ_HALT} seq_phase_type;

   localparam int REPORT_LIMIT = 10;

   class sweep_checker;
      logic [ADDR_W-1:0] first_addr;
      logic [ADDR_W-1:0] last_addr;
      logic [ADDR_W-1:0] cur_addr;
      logic [LINE_W-1:0] line_idx;
      logic [DATA_W-1:0] pattern;
      seq_phase_type     phase;
      rsp_type           expected_beats[$];
      int unsigned       mismatches;

      function new();
         first_addr = START_RESET;
         last_addr  = END_RESET;
         cur_addr   = START_RESET;
         line_idx   = '0;
         pattern    = PAT_ZERO;
         phase      = SEQ_IDLE;
         mismatches = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [ADDR_W-1:0] value);
         if (idx == CSR_START) first_addr = value;
         else last_addr = value;
      endfunction

      // Address under test plus two to the power of i, wrapping at the address width.
      function logic [ADDR_W-1:0] offset_addr(int unsigned i);
         return cur_addr + (ADDR_W'(1) << i);
      endfunction

      function void add_beat(logic [KIND_W-1:0] kind, logic [ADDR_W-1:0] addr,
                             logic [DATA_W-1:0] data, logic [LINE_W-1:0] line,
                             logic [DATA_W-1:0] mask);
         rsp_type beat;
         beat.kind     = kind;
         beat.address  = addr;
         beat.data     = data;
         beat.line     = line;
         beat.bit_mask = mask;
         beat.last     = 1'b0;
         expected_beats.push_back(beat);
      endfunction

      function void open_address();
         for (int i = 0; i < ADDR_LINES; i++) add_beat(KIND_WRITE, offset_addr(i), PAT_ZERO, '0, '0);
         add_beat(KIND_WRITE, cur_addr, PAT_ONES, '0, '0);
         line_idx = LINE_W'(1);
         add_beat(KIND_READ, offset_addr(1), PAT_ZERO, '0, '0);
         phase = SEQ_LINES;
      endfunction

      function void write_then_read(logic [DATA_W-1:0] pat);
         pattern = pat;
         add_beat(KIND_WRITE, cur_addr, pattern, '0, '0);
         add_beat(KIND_READ, cur_addr, PAT_ZERO, '0, '0);
      endfunction

      function void note_request(req_type req);
         int queued;
         queued = expected_beats.size();
         if (req.op == OP_START) begin
            cur_addr = first_addr;
            pattern  = PAT_ZERO;
            open_address();
         end else begin
            case (phase)
               SEQ_LINES: begin
                  if (req.read_data != PAT_ZERO) begin
                     add_beat(KIND_AFAULT, cur_addr, req.read_data, line_idx, '0);
                     add_beat(KIND_WRITE, offset_addr(line_idx), PAT_ZERO, '0, '0);
                  end
                  line_idx = line_idx + 1'b1;
                  if (line_idx != 0 && line_idx < ADDR_LINES) begin
                     add_beat(KIND_READ, offset_addr(line_idx), PAT_ZERO, '0, '0);
                  end else begin
                     line_idx = '0;
                     write_then_read(PAT_A);
                     phase = SEQ_CHECK;
                  end
               end
               SEQ_CHECK: begin
                  if (req.read_data == pattern) begin
                     if (pattern == PAT_A) begin
                        write_then_read(PAT_B);
                     end else if (cur_addr == last_addr) begin
                        add_beat(KIND_PASS, cur_addr, PAT_ZERO, '0, '0);
                        phase = SEQ_HALT;
                     end else begin
                        cur_addr = cur_addr + 1'b1;
                        open_address();
                     end
                  end else if (req.read_data == PAT_ZERO) begin
                     add_beat(KIND_CATA, cur_addr, pattern, '0, '0);
                     phase = SEQ_HALT;
                  end else begin
                     add_beat(KIND_DFAULT, cur_addr, pattern, '0, req.read_data ^ pattern);
                     write_then_read(pattern == PAT_A ? PAT_B : PAT_A);
                     phase = SEQ_COMPL;
                  end
               end
               SEQ_COMPL: begin
                  add_beat(KIND_COMPL, cur_addr, req.read_data, '0, req.read_data ^ pattern);
                  phase = SEQ_HALT;
               end
               default: ;
            endcase
         end
         if (expected_beats.size() > queued) expected_beats[$].last = 1'b1;
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (expected_beats.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: unexpected beat kind %0d addr %h data %h line %0d mask %h last %b",
                        $time, got.kind, got.address, got.data, got.line, got.bit_mask, got.last);
            return;
         end
         want = expected_beats.pop_front();
         if (got.kind !== want.kind || got.address !== want.address || got.data !== want.data ||
             got.line !== want.line || got.bit_mask !== want.bit_mask || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("%0t: expected kind %0d addr %h data %h line %0d mask %h last %b",
                        $time, want.kind, want.address, want.data, want.line, want.bit_mask,
                        want.last);
               $display("%0t:   actual kind %0d addr %h data %h line %0d mask %h last %b",
                        $time, got.kind, got.address, got.data, got.line, got.bit_mask, got.last);
            end
         end
      endfunction

      function int unsigned pending();
         return expected_beats.size();
      endfunction
   endclass

endpackage

// ----- verif/tb.sv -----
// Top-level testbench for memory_test_sequencer_top: clock, reset, stimulus and result checks.
// Depends on mts_pkg for the beat types and on mts_tb_pkg for the sweep scoreboard.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mts_pkg::*;
   import mts_tb_pkg::*;

   // A cycle with no beat accepted on either side counts towards the stall limit. The
   // longest legitimate quiet stretch is a settle pause or an idle burst plus the trip
   // through the pipeline, so this leaves a very wide margin.
   localparam int STALL_LIMIT   = 5000;
   localparam int SETTLE_CYCLES = 24;
   localparam int PHASE_ITEMS   = 52;
   localparam int RANDOM_PHASES = 8;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [ADDR_W-1:0]    csr_wdata;
   logic                 req_push;
   logic                 req_full;
   req_type              req_data;
   logic                 rsp_empty;
   logic                 rsp_pop = 1'b0;
   rsp_type              rsp_data;

   sweep_checker sweep;
   bit           quiet = 1'b0;
   int unsigned  idle_cycles = 0;
   int unsigned  pop_hold = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   memory_test_sequencer_top uut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   // Result side: pop is driven on the falling edge. Stalls come in bursts now and then,
   // and once the quiet flag is set the receiver takes every beat at once.
   always @(negedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (pop_hold != 0) begin
         rsp_pop <= 1'b0;
         pop_hold = pop_hold - 1;
      end else if (!quiet && $urandom_range(0, 99) < 6) begin
         rsp_pop <= 1'b0;
         pop_hold = $urandom_range(1, 18) - 1;
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   // Every accepted result beat is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) sweep.check_response(rsp_data);
   end

   // Watchdog: ends the run if nothing moves on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Optionally drops push for a burst ahead of the next beat. The next call of send_beat
   // raises push again on a later falling edge, never the same one.
   task automatic sender_gap();
      int unsigned span;
      if (!quiet && $urandom_range(0, 99) < 15) begin
         span = $urandom_range(1, 18);
         @(negedge clock);
         req_push <= 1'b0;
         repeat (span - 1) @(negedge clock);
      end
   endtask

   // Presents one request beat and holds it until the sequencer takes it. Push stays high
   // on return so that back-to-back beats need no extra edge in between.
   task automatic send_beat(logic op, logic [DATA_W-1:0] value);
      req_type item;
      item.op        = op;
      item.read_data = value;
      sender_gap();
      @(negedge clock);
      req_push <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_full) @(posedge clock);
      sweep.note_request(item);
   endtask

   // Stops the request side, waits for every predicted beat, then lets the pipeline settle
   // in case the last requests were ones that produce nothing.
   task automatic quiesce();
      @(negedge clock);
      req_push <= 1'b0;
      while (sweep.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [ADDR_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      sweep.write_reg(idx, value);
   endtask

   // Read data that a memory would mostly return at this point of the sweep: zero for the
   // address-line reads and the written pattern for the check reads. Now and then a fault
   // is injected instead, so that every reporting path is reached.
   function automatic logic [DATA_W-1:0] pick_read_data();
      logic [DATA_W-1:0] noise;
      int unsigned       roll;
      noise = DATA_W'($urandom_range(1, 255));
      roll  = $urandom_range(0, 99);
      case (sweep.phase)
         SEQ_LINES: return (roll < 90) ? PAT_ZERO : noise;
         SEQ_CHECK: begin
            if (roll < 88) return sweep.pattern;
            else if (roll < 94) return PAT_ZERO;
            else return noise;
         end
         SEQ_COMPL: return (roll < 50) ? sweep.pattern : noise;
         default:   return noise;
      endcase
   endfunction

   // Random traffic. While the sequencer is idle or halted it is mostly restarted; stray
   // read beats there are ignored by the block and are not counted. While a sweep runs,
   // a few restarts are mixed in with the read data.
   task automatic run_random(int unsigned count);
      int unsigned sent;
      sent = 0;
      while (sent < count) begin
         if (sweep.phase == SEQ_IDLE || sweep.phase == SEQ_HALT) begin
            if ($urandom_range(0, 99) < 15) begin
               send_beat(OP_READ, DATA_W'($urandom_range(0, 255)));
            end else begin
               send_beat(OP_START, DATA_W'($urandom_range(0, 255)));
               sent++;
            end
         end else if ($urandom_range(0, 99) < 3) begin
            send_beat(OP_START, DATA_W'($urandom_range(0, 255)));
            sent++;
         end else begin
            send_beat(OP_READ, pick_read_data());
            sent++;
         end
      end
   endtask

   initial begin
      int unsigned       phase_no;
      logic [ADDR_W-1:0] lo;
      logic [ADDR_W-1:0] hi;

      reset     = 1'b1;
      csr_we    = 1'b0;
      csr_index = CSR_START;
      csr_wdata = '0;
      req_push  = 1'b0;
      req_data  = '0;
      sweep     = new();

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part, with the registers at their reset values.
      // Read data before any start is ignored.
      send_beat(OP_READ, 8'h5A);
      send_beat(OP_START, PAT_ONES);
      // Address-line reads: a fault with all bits set on the first line, clean lines in
      // the middle and a single-bit fault on the last line.
      send_beat(OP_READ, PAT_ONES);
      repeat (8) send_beat(OP_READ, PAT_ZERO);
      send_beat(OP_READ, 8'h01);
      // The 0xAA check passes, the 0x55 check fails with a non-zero value, and the
      // complement readback then matches, so it is reported with an empty mask.
      send_beat(OP_READ, PAT_A);
      send_beat(OP_READ, 8'h54);
      send_beat(OP_READ, PAT_A);
      // Halted: read data is ignored, then a start restarts the sweep, and a second start
      // in the middle of the address-line reads restarts it again.
      send_beat(OP_READ, 8'h80);
      send_beat(OP_START, PAT_ZERO);
      send_beat(OP_READ, PAT_ZERO);
      send_beat(OP_START, 8'h7F);

      // Random phases, each with its own address range. The first four cover the extremes:
      // a single address at zero, a range that wraps through zero, the top of the space and
      // a start above the end. The rest use short random ranges so that the pass report is
      // reached often. The last phase runs without idling on either side.
      for (phase_no = 0; phase_no < RANDOM_PHASES; phase_no++) begin
         quiesce();
         case (phase_no)
            0: begin lo = 16'h0000; hi = 16'h0000; end
            1: begin lo = 16'hFFFF; hi = 16'h0001; end
            2: begin lo = 16'hFFFE; hi = 16'hFFFF; end
            3: begin lo = 16'h0005; hi = 16'h0003; end
            default: begin
               lo = ADDR_W'($urandom);
               hi = lo + ADDR_W'($urandom_range(0, 2));
            end
         endcase
         write_reg(CSR_START, lo);
         write_reg(CSR_END, hi);
         quiet = (phase_no == RANDOM_PHASES - 1);
         run_random(PHASE_ITEMS);
      end

      quiesce();
      if (sweep.mismatches == 0 && sweep.pending() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
